/* src/lrs_pkg.sv */
`timescale 1ns / 1ps
package lrs_pkg;

	localparam int MAX_LEN = 1024;
	localparam int AW = $clog2(MAX_LEN);
	localparam int NW = AW + 1;
	localparam int KW = AW + 2;
	localparam logic [7:0] SENTINEL = 8'd35;
	localparam logic [9:0] MIN_LEN_RESET = 10'd3;

	typedef struct packed {
		logic [7:0] symbol;
		logic       last;
	} item_t;

	typedef struct packed {
		logic       found;
		logic [9:0] repeat_length;
		logic [9:0] repeat_start;
		logic       overflow;
	} result_t;

endpackage

/* src/longest_repeated_substring_top.sv */
`timescale 1ns / 1ps
// channel   direction  handshake                 payload
// item      in         item_valid / item_stall   lrs_pkg::item_t
// result    out        result_valid / result_stall lrs_pkg::result_t
// cfg       in         cfg_valid / cfg_ready     min_len (10 bits)
//
// loading takes one cycle per byte; the item marked last starts the build
// each doubling round runs two radix passes with count clear and prefix sum
// over a 2048 entry count memory, then relabel
// ceil(log2 n) rounds are followed by the lcp build
// and then the search
// input is stalled while the build runs; the result sits in an output register
// reset clears control state only; memories hold undefined data until written
module longest_repeated_substring_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  lrs_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output lrs_pkg::result_t  result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [9:0]        cfg_data
);
	import lrs_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SENT = 4'd1;
	localparam logic [3:0] S_INIT = 4'd2;
	localparam logic [3:0] S_CLR  = 4'd3;
	localparam logic [3:0] S_HIST = 4'd4;
	localparam logic [3:0] S_PSUM = 4'd5;
	localparam logic [3:0] S_SCAT = 4'd6;
	localparam logic [3:0] S_REL  = 4'd7;
	localparam logic [3:0] S_PREV = 4'd8;
	localparam logic [3:0] S_KAS  = 4'd9;
	localparam logic [3:0] S_FIND = 4'd10;
	localparam logic [3:0] S_DONE = 4'd11;

	localparam logic [KW-1:0] CNT_LAST = KW'(2 * MAX_LEN - 1);

	logic [3:0]    state_q;
	logic [2:0]    ph_q;
	logic [KW-1:0] i_q;
	logic [NW-1:0] n_q;
	logic [KW-1:0] k_q;
	logic [NW-1:0] cnt_q;
	logic          ovf_q;
	logic          ovf_res_q;
	logic          pass_q;
	logic          cur_q;
	logic [AW-1:0] x_q;
	logic          zero_q;
	logic [NW-1:0] key_q;
	logic [NW-1:0] sum_q;
	logic [NW-1:0] r_q;
	logic [NW-1:0] pr1_q;
	logic [NW-1:0] pr2_q;
	logic [NW-1:0] r1_q;
	logic [AW-1:0] len_q;
	logic [AW-1:0] p_q;
	logic [7:0]    t1_q;
	logic [AW-1:0] best_q;
	logic [AW-1:0] start_q;
	logic          found_q;
	logic [9:0]    min_len_q;
	logic          res_valid_q;
	result_t       res_q;

	logic [7:0]    txt_mem [MAX_LEN];
	logic [AW-1:0] ord_mem [2*MAX_LEN];
	logic [NW-1:0] rk_mem  [2*MAX_LEN];
	logic [NW-1:0] cn_mem  [2*MAX_LEN];
	logic [NW-1:0] pv_mem  [MAX_LEN];
	logic [AW-1:0] lc_mem  [MAX_LEN];

	logic          txt_we, ord_we, rk_we, cn_we, pv_we, lc_we;
	logic [AW-1:0] txt_ra, txt_wa, pv_ra, pv_wa, lc_ra, lc_wa;
	logic [AW:0]   ord_ra, ord_wa, rk_ra, rk_wa, cn_ra, cn_wa;
	logic [7:0]    txt_wd, txt_rd_q;
	logic [AW-1:0] ord_wd, ord_rd_q, lc_wd, lc_rd_q;
	logic [NW-1:0] rk_wd, rk_rd_q, cn_wd, cn_rd_q, pv_wd, pv_rd_q;

	logic          in_acc;
	logic [KW-1:0] hist_pos, rel_pos, kas_a, kas_b;
	logic [NW-1:0] rel_r2, rel_new, hist_key;
	logic          rel_diff;
	logic [KW-1:0] k_next;

	assign in_acc       = item_valid && !item_stall;
	assign item_stall   = (state_q != S_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	assign hist_pos = KW'(ord_rd_q) + k_q;
	assign rel_pos  = KW'(x_q) + k_q;
	assign kas_a    = KW'(i_q[AW-1:0]) + KW'(len_q);
	assign kas_b    = KW'(p_q) + KW'(len_q);
	assign hist_key = zero_q ? '0 : rk_rd_q;
	assign rel_r2   = zero_q ? '0 : rk_rd_q;
	assign rel_diff = (r1_q != pr1_q) || (rel_r2 != pr2_q);
	assign rel_new  = (i_q == '0) ? NW'(1) : r_q + NW'(rel_diff);
	assign k_next   = k_q << 1;

	always_ff @(posedge clk) begin
		if (txt_we) txt_mem[txt_wa] <= txt_wd;
		txt_rd_q <= txt_mem[txt_ra];
	end
	always_ff @(posedge clk) begin
		if (ord_we) ord_mem[ord_wa] <= ord_wd;
		ord_rd_q <= ord_mem[ord_ra];
	end
	always_ff @(posedge clk) begin
		if (rk_we) rk_mem[rk_wa] <= rk_wd;
		rk_rd_q <= rk_mem[rk_ra];
	end
	always_ff @(posedge clk) begin
		if (cn_we) cn_mem[cn_wa] <= cn_wd;
		cn_rd_q <= cn_mem[cn_ra];
	end
	always_ff @(posedge clk) begin
		if (pv_we) pv_mem[pv_wa] <= pv_wd;
		pv_rd_q <= pv_mem[pv_ra];
	end
	always_ff @(posedge clk) begin
		if (lc_we) lc_mem[lc_wa] <= lc_wd;
		lc_rd_q <= lc_mem[lc_ra];
	end

	always_comb begin
		txt_we = 1'b0; txt_wa = cnt_q[AW-1:0]; txt_wd = item.symbol; txt_ra = i_q[AW-1:0];
		ord_we = 1'b0; ord_wa = '0; ord_wd = '0; ord_ra = {pass_q, i_q[AW-1:0]};
		rk_we = 1'b0; rk_wa = '0; rk_wd = '0; rk_ra = {cur_q, ord_rd_q};
		cn_we = 1'b0; cn_wa = i_q[AW:0]; cn_wd = '0; cn_ra = i_q[AW:0];
		pv_we = 1'b0; pv_wa = ord_rd_q; pv_wd = '0; pv_ra = i_q[AW-1:0];
		lc_we = 1'b0; lc_wa = i_q[AW-1:0]; lc_wd = len_q; lc_ra = ord_rd_q;
		unique case (state_q)
			S_IDLE: begin
				txt_we = in_acc && (cnt_q < NW'(MAX_LEN - 1));
			end
			S_SENT: begin
				txt_we = 1'b1;
				txt_wd = SENTINEL;
			end
			S_INIT: begin
				if (ph_q == 3'd1) begin
					ord_we = 1'b1;
					ord_wa = {1'b0, i_q[AW-1:0]};
					ord_wd = i_q[AW-1:0];
					rk_we  = 1'b1;
					rk_wa  = {cur_q, i_q[AW-1:0]};
					rk_wd  = NW'(txt_rd_q) + NW'(1);
				end
			end
			S_CLR: begin
				cn_we = 1'b1;
			end
			S_HIST, S_SCAT: begin
				if (ph_q == 3'd1 && !pass_q) rk_ra = {cur_q, hist_pos[AW-1:0]};
				cn_ra = hist_key;
				if (ph_q == 3'd3) begin
					cn_we = 1'b1;
					cn_wa = key_q;
					cn_wd = cn_rd_q + NW'(1);
					if (state_q == S_SCAT) begin
						ord_we = 1'b1;
						ord_wa = {!pass_q, cn_rd_q[AW-1:0]};
						ord_wd = x_q;
					end
				end
			end
			S_PSUM: begin
				if (ph_q == 3'd1) begin
					cn_we = 1'b1;
					cn_wd = sum_q;
				end
			end
			S_REL: begin
				ord_ra = {1'b0, i_q[AW-1:0]};
				if (ph_q == 3'd2) rk_ra = {cur_q, rel_pos[AW-1:0]};
				if (ph_q == 3'd3) begin
					rk_we = 1'b1;
					rk_wa = {!cur_q, x_q};
					rk_wd = rel_new;
				end
			end
			S_PREV: begin
				ord_ra = {1'b0, i_q[AW-1:0]};
				if (ph_q == 3'd1) begin
					pv_we = 1'b1;
					pv_wd = (i_q == '0) ? n_q : NW'(x_q);
				end
			end
			S_KAS: begin
				if (ph_q == 3'd2) txt_ra = kas_a[AW-1:0];
				if (ph_q == 3'd3) txt_ra = kas_b[AW-1:0];
				if (ph_q == 3'd1 && pv_rd_q >= n_q) begin
					lc_we = 1'b1;
					lc_wd = '0;
				end
				if (ph_q == 3'd5) lc_we = 1'b1;
			end
			S_FIND: begin
				ord_ra = {1'b0, i_q[AW-1:0]};
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= '0;
			i_q         <= '0;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			pass_q      <= 1'b0;
			cur_q       <= 1'b0;
			min_len_q   <= MIN_LEN_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) min_len_q <= cfg_data;
			if (res_valid_q && !result_stall && state_q != S_DONE) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (cnt_q < NW'(MAX_LEN - 1)) cnt_q <= cnt_q + NW'(1);
						else ovf_q <= 1'b1;
						if (item.last) state_q <= S_SENT;
					end
				end
				S_SENT: begin
					n_q       <= cnt_q + NW'(1);
					ovf_res_q <= ovf_q;
					cnt_q     <= '0;
					ovf_q     <= 1'b0;
					i_q       <= '0;
					ph_q      <= '0;
					state_q   <= S_INIT;
				end
				S_INIT: begin
					if (ph_q == 3'd0) begin
						ph_q <= 3'd1;
					end else begin
						ph_q <= 3'd0;
						if (i_q == KW'(n_q) - KW'(1)) begin
							i_q <= '0;
							k_q <= KW'(1);
							pass_q <= 1'b0;
							state_q <= (n_q > NW'(1)) ? S_CLR : S_PREV;
						end else begin
							i_q <= i_q + KW'(1);
						end
					end
				end
				S_CLR: begin
					if (i_q == CNT_LAST) begin
						i_q <= '0;
						ph_q <= '0;
						state_q <= S_HIST;
					end else begin
						i_q <= i_q + KW'(1);
					end
				end
				S_HIST, S_SCAT: begin
					unique case (ph_q)
						3'd0: ph_q <= 3'd1;
						3'd1: begin
							x_q <= ord_rd_q;
							zero_q <= !pass_q && (hist_pos >= KW'(n_q));
							ph_q <= 3'd2;
						end
						3'd2: begin
							key_q <= hist_key;
							ph_q <= 3'd3;
						end
						default: begin
							ph_q <= 3'd0;
							if (i_q == KW'(n_q) - KW'(1)) begin
								i_q <= '0;
								sum_q <= '0;
								if (state_q == S_HIST) begin
									state_q <= S_PSUM;
								end else if (!pass_q) begin
									pass_q <= 1'b1;
									state_q <= S_CLR;
								end else begin
									pass_q <= 1'b0;
									state_q <= S_REL;
								end
							end else begin
								i_q <= i_q + KW'(1);
							end
						end
					endcase
				end
				S_PSUM: begin
					if (ph_q == 3'd0) begin
						ph_q <= 3'd1;
					end else begin
						ph_q <= 3'd0;
						sum_q <= sum_q + cn_rd_q;
						if (i_q == CNT_LAST) begin
							i_q <= '0;
							state_q <= S_SCAT;
						end else begin
							i_q <= i_q + KW'(1);
						end
					end
				end
				S_REL: begin
					unique case (ph_q)
						3'd0: ph_q <= 3'd1;
						3'd1: begin
							x_q <= ord_rd_q;
							ph_q <= 3'd2;
						end
						3'd2: begin
							r1_q <= rk_rd_q;
							zero_q <= (rel_pos >= KW'(n_q));
							ph_q <= 3'd3;
						end
						default: begin
							r_q <= rel_new;
							pr1_q <= r1_q;
							pr2_q <= rel_r2;
							ph_q <= 3'd0;
							if (i_q == KW'(n_q) - KW'(1)) begin
								i_q <= '0;
								cur_q <= !cur_q;
								k_q <= k_next;
								state_q <= (k_next < KW'(n_q)) ? S_CLR : S_PREV;
							end else begin
								i_q <= i_q + KW'(1);
							end
						end
					endcase
				end
				S_PREV: begin
					if (ph_q == 3'd0) begin
						ph_q <= 3'd1;
					end else begin
						ph_q <= 3'd0;
						x_q <= ord_rd_q;
						if (i_q == KW'(n_q) - KW'(1)) begin
							i_q <= '0;
							len_q <= '0;
							best_q <= '0;
							state_q <= S_KAS;
						end else begin
							i_q <= i_q + KW'(1);
						end
					end
				end
				S_KAS: begin
					unique case (ph_q)
						3'd0: ph_q <= 3'd1;
						3'd1: begin
							if (pv_rd_q >= n_q) begin
								len_q <= '0;
								ph_q <= 3'd0;
								if (i_q == KW'(n_q) - KW'(1)) begin
									i_q <= '0;
									state_q <= S_FIND;
								end else begin
									i_q <= i_q + KW'(1);
								end
							end else begin
								p_q <= pv_rd_q[AW-1:0];
								ph_q <= 3'd2;
							end
						end
						3'd2: begin
							ph_q <= (kas_a < KW'(n_q) && kas_b < KW'(n_q)) ? 3'd3 : 3'd5;
						end
						3'd3: begin
							t1_q <= txt_rd_q;
							ph_q <= 3'd4;
						end
						3'd4: begin
							if (t1_q == txt_rd_q) begin
								len_q <= len_q + AW'(1);
								ph_q <= 3'd2;
							end else begin
								ph_q <= 3'd5;
							end
						end
						default: begin
							if (len_q > best_q) best_q <= len_q;
							if (len_q != '0) len_q <= len_q - AW'(1);
							ph_q <= 3'd0;
							if (i_q == KW'(n_q) - KW'(1)) begin
								i_q <= '0;
								state_q <= S_FIND;
							end else begin
								i_q <= i_q + KW'(1);
							end
						end
					endcase
				end
				S_FIND: begin
					found_q <= (10'(best_q) >= min_len_q);
					unique case (ph_q)
						3'd0: begin
							start_q <= '0;
							if (10'(best_q) >= min_len_q) ph_q <= 3'd1;
							else state_q <= S_DONE;
						end
						3'd1: begin
							x_q <= ord_rd_q;
							ph_q <= 3'd2;
						end
						default: begin
							if (lc_rd_q == best_q || i_q == KW'(n_q) - KW'(1)) begin
								start_q <= x_q;
								state_q <= S_DONE;
							end else begin
								i_q <= i_q + KW'(1);
								ph_q <= 3'd0;
							end
						end
					endcase
				end
				S_DONE: begin
					if (!res_valid_q || !result_stall) begin
						res_q.found         <= found_q;
						res_q.repeat_length <= 10'(best_q);
						res_q.repeat_start  <= 10'(start_q);
						res_q.overflow      <= ovf_res_q;
						res_valid_q         <= 1'b1;
						ph_q                <= '0;
						state_q             <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NW'(MAX_LEN - 1))
		else $error("text count beyond capacity");

	a_rel_k: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REL) |-> (k_q < KW'(n_q)))
		else $error("relabel with doubling step past text end");

	a_kas_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_KAS) |-> (NW'(len_q) < n_q))
		else $error("match length past text end");

	a_find_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIND) |-> (i_q < KW'(n_q)))
		else $error("search index past suffix count");

endmodule
